@@ sv/skyf_pkg.sv @@
// ----------------------------------------------------------------------------
// skyf_pkg
// Shared types and constants for the scalar yaw fusion core.
// ----------------------------------------------------------------------------
package skyf_pkg;

	localparam int CordicSteps = 20;
	localparam int StepW = 5;
	localparam logic signed [23:0] OneQ21 = 24'sd2097152;
	localparam logic signed [23:0] ClampQ21 = 24'sd2095055;
	localparam logic signed [23:0] NinetyQ16 = 24'sd5898240;
	localparam logic [17:0] PMax = 18'd262143;
	localparam logic signed [14:0] YawNinety = 15'sd11520;

	localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
	localparam logic [1:0] REG_MEAS_NOISE = 2'd1;
	localparam logic [1:0] REG_INIT_COV = 2'd2;

	localparam logic [1:0] EDGE_RIGHT = 2'd0;
	localparam logic [1:0] EDGE_LEFT = 2'd1;
	localparam logic [1:0] EDGE_TOP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CORDIC,
		ST_ROUND,
		ST_GAIN_SETUP,
		ST_DIV,
		ST_GAIN,
		ST_FUSE,
		ST_COV,
		ST_OUT
	} state_t;

	function automatic logic [21:0] atan_lut(input logic [StepW-1:0] i);
		logic [21:0] r;
		case (i)
			5'd0: r = 22'd2949120;
			5'd1: r = 22'd1740967;
			5'd2: r = 22'd919879;
			5'd3: r = 22'd466945;
			5'd4: r = 22'd234379;
			5'd5: r = 22'd117304;
			5'd6: r = 22'd58666;
			5'd7: r = 22'd29335;
			5'd8: r = 22'd14668;
			5'd9: r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/scalar_kalman_yaw_fusion_core.sv @@
// sequence: input transfer, clamp, 20 cordic rotations (skipped at zero position),
//   gain setup, 36 divider steps (skipped when the gain denominator is zero),
//   fuse and covariance multiply states, then the result register
// flow: one item at a time; input is held off while busy,
//   and a result still waiting in the output register holds the last state
// reset: noise registers take 26 and 2560, covariance loads 25600
// ----------------------------------------------------------------------------
// scalar_kalman_yaw_fusion_core
// Model yaw from an arctangent, blended with the camera yaw by a scalar
// Kalman step under a small sequencer.
// ----------------------------------------------------------------------------
module scalar_kalman_yaw_fusion_core import skyf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        speed,
	input  logic [15:0]        edge_time,
	input  logic [1:0]         edge_index,
	input  logic signed [15:0] camera_yaw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] fused_yaw,
	output logic signed [14:0] geo_yaw,
	output logic [15:0]        filter_gain,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	state_t state_q, state_d;
	logic [15:0] pn_q, rn_q;
	logic [17:0] cov_q;
	logic [31:0] u_q;
	logic [1:0] edge_q;
	logic signed [15:0] cam_q;
	logic signed [24:0] n_q;
	logic signed [14:0] model_q;
	logic [17:0] p1_q;
	logic [18:0] d_q;
	logic [15:0] gain_q;
	logic signed [15:0] fused_q;
	logic signed [33:0] prod_q;
	logic out_valid_q;
	logic signed [15:0] res_fused_q;
	logic signed [14:0] res_model_q;
	logic [15:0] res_gain_q;

	logic cordic_start, cordic_done, div_start, div_done;
	logic out_load;
	logic [13:0] cordic_angle;
	logic [35:0] quot;
	logic [21:0] nmag;
	logic signed [33:0] u_s;
	logic signed [33:0] n_raw;
	logic [18:0] p1_sum;
	logic [35:0] qr;
	logic signed [16:0] diff;

	always_comb begin
		u_s = $signed({2'b0, u_q});
		case (edge_q)
			EDGE_RIGHT: n_raw = 34'(OneQ21) - u_s;
			EDGE_LEFT:  n_raw = -(u_s + 34'(OneQ21));
			EDGE_TOP:   n_raw = u_s - 34'(OneQ21);
			default:    n_raw = u_s + 34'(OneQ21);
		endcase
		nmag = (n_q < 0) ? 22'(-n_q) : 22'(n_q);
		p1_sum = {1'b0, cov_q} + {3'b0, pn_q};
		// rounded quotient; result saturates above 16 bits
		qr = quot;
		diff = 17'(cam_q) - 17'(model_q);
	end

	skyf_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start), .mag_in(nmag),
		.done(cordic_done), .angle(cordic_angle)
	);

	// numerator p1*2^17 + d gives twice the quotient plus the rounding bit
	skyf_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, p1_q, 17'b0} + {17'b0, d_q}),
		.den(d_q), .done(div_done), .quot(quot)
	);

	always_comb begin
		state_d = state_q;
		cordic_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PREP;
			ST_PREP: state_d = ST_CORDIC;
			ST_CORDIC: begin
				if (n_q == 0) begin
					state_d = ST_GAIN_SETUP;
				end else begin
					cordic_start = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: if (cordic_done) state_d = ST_GAIN_SETUP;
			ST_GAIN_SETUP: state_d = ST_DIV;
			ST_DIV: begin
				if (d_q == '0) begin
					state_d = ST_FUSE;
				end else begin
					div_start = 1'b1;
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: if (div_done) state_d = ST_FUSE;
			ST_FUSE: state_d = ST_COV;
			ST_COV: state_d = ST_OUT;
			ST_OUT: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_load = (state_q == ST_OUT) && (state_d == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pn_q <= 16'd26;
			rn_q <= 16'd2560;
			cov_q <= 18'd25600;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROCESS_NOISE: pn_q <= cfg_data;
					REG_MEAS_NOISE: rn_q <= cfg_data;
					REG_INIT_COV: cov_q <= {2'b0, cfg_data};
					default: ;
				endcase
			end
			if (out_load) begin
				cov_q <= 18'((prod_q[33:0] + 34'd32768) >> 16);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				u_q <= speed * edge_time;
				edge_q <= edge_index;
				cam_q <= camera_yaw;
			end
			ST_PREP: begin
				if (n_raw > 34'(ClampQ21)) begin
					n_q <= 25'(ClampQ21);
				end else if (n_raw < -34'(ClampQ21)) begin
					n_q <= -25'(ClampQ21);
				end else begin
					n_q <= 25'(n_raw);
				end
			end
			ST_CORDIC: if (n_q == 0) begin
				model_q <= (edge_q == EDGE_RIGHT) ? -YawNinety : YawNinety;
			end
			ST_ROUND: if (cordic_done) begin
				model_q <= (n_q < 0) ? -$signed({1'b0, cordic_angle}) :
					$signed({1'b0, cordic_angle});
			end
			ST_GAIN_SETUP: begin
				p1_q <= p1_sum[18] ? PMax : p1_sum[17:0];
				gain_q <= '0;
				d_q <= (p1_sum[18] ? {1'b0, PMax} : {1'b0, p1_sum[17:0]}) + {3'b0, rn_q};
			end
			ST_GAIN: if (div_done) begin
				gain_q <= (|qr[35:17]) ? 16'hFFFF : 16'(qr[16:1]);
			end
			ST_FUSE: prod_q <= 34'($signed({1'b0, gain_q}) * diff);
			ST_COV: begin
				fused_q <= 16'(model_q + 16'(((prod_q + 34'sd32768) >>> 16)));
				prod_q <= 34'({1'b0, 17'd65536 - {1'b0, gain_q}} * p1_q);
			end
			default: ;
		endcase
		if (out_load) begin
			res_fused_q <= fused_q;
			res_model_q <= model_q;
			res_gain_q <= gain_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign out_valid = out_valid_q;
	assign fused_yaw = res_fused_q;
	assign geo_yaw = res_model_q;
	assign filter_gain = res_gain_q;

endmodule

@@ sv/skyf_cordic.sv @@
// ----------------------------------------------------------------------------
// skyf_cordic
// Vectoring cordic arctangent, one rotation per cycle, with result rounding.
// ----------------------------------------------------------------------------
module skyf_cordic import skyf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [21:0]        mag_in,
	output logic               done,
	output logic [13:0]        angle
);

	logic signed [33:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic [StepW-1:0] i_q;
	logic busy_q, fin_q;
	logic signed [33:0] ysh, xsh;
	logic signed [25:0] mag;

	// truncate toward zero on shifts
	always_comb begin
		if (y_q < 0) begin
			ysh = -((-y_q) >>> i_q);
		end else begin
			ysh = y_q >>> i_q;
		end
		xsh = x_q >>> i_q;
		mag = 26'(NinetyQ16) - z_q;
		if (mag < 0) begin
			mag = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			i_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == StepW'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 34'sd1 <<< 30;
			y_q <= $signed({3'b0, mag_in, 9'b0});
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ysh;
				y_q <= y_q - xsh;
				z_q <= z_q + $signed({4'b0, atan_lut(i_q)});
			end else begin
				x_q <= x_q - ysh;
				y_q <= y_q + xsh;
				z_q <= z_q - $signed({4'b0, atan_lut(i_q)});
			end
		end
	end

	assign done = fin_q;
	assign angle = 14'((mag + 26'sd256) >>> 9);

endmodule

@@ sv/skyf_divider.sv @@
// ----------------------------------------------------------------------------
// skyf_divider
// Restoring radix-2 divider for the gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module skyf_divider import skyf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [35:0] num,
	input  logic [18:0] den,
	output logic        done,
	output logic [35:0] quot
);

	logic [35:0] q_q;
	logic [18:0] r_q;
	logic [18:0] d_q;
	logic [5:0] cnt_q;
	logic busy_q, fin_q;
	logic [19:0] r_sh;
	logic [20:0] diff;

	always_comb begin
		r_sh = {r_q, q_q[35]};
		diff = {1'b0, r_sh} - {2'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd35) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so 19 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[20]) begin
				r_q <= diff[18:0];
				q_q <= {q_q[34:0], 1'b1};
			end else begin
				r_q <= r_sh[18:0];
				q_q <= {q_q[34:0], 1'b0};
			end
		end
	end

	assign done = fin_q;
	assign quot = q_q;

endmodule

@@ sv/skyf_checker.sv @@
// ----------------------------------------------------------------------------
// skyf_checker
// Port-level checks on the fusion core, bound to the top level.
// ----------------------------------------------------------------------------
module skyf_checker import skyf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready,
	input logic [15:0] filter_gain
);

	// one item at a time: no new transfer right after one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("busy not held");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> in_ready) else $error("config taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filter_gain))
		else $error("result dropped");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || $past(out_valid))
		else $error("result too early");

endmodule

bind scalar_kalman_yaw_fusion_core skyf_checker u_skyf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready),
	.filter_gain(filter_gain)
);

@@ tb/sv/tb_scalar_kalman_yaw_fusion_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_yaw_fusion_core
// Self-checking bench for the yaw fusion core. A local predictor computes the
// model yaw, gain and fused yaw of each transfer; results are compared in
// order. Covers field extremes, special cases, register settings and random
// traffic with bursty input and stalling output.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_yaw_fusion_core import skyf_pkg::*; ();

	typedef struct packed {
		logic signed [15:0] fused;
		logic signed [14:0] model;
		logic [15:0]        gain;
	} yaw_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        speed = '0;
	logic [15:0]        edge_time = '0;
	logic [1:0]         edge_index = '0;
	logic signed [15:0] camera_yaw = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] fused_yaw;
	logic signed [14:0] geo_yaw;
	logic [15:0]        filter_gain;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	// predictor state
	logic [15:0] q_noise, r_noise, p_init;
	logic [17:0] cov;

	yaw_result_t expected_q[$];
	int  errors = 0;
	int  cycles = 0;
	int  burst_left = 0;
	bit  hold_off = 1'b0;
	bit  no_stall = 1'b0;
	int  stall_mode = 0;

	localparam int CycleLimit = 2000000;
	localparam int Drain = 150;

	scalar_kalman_yaw_fusion_core i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("scalar_kalman_yaw_fusion_core regression: fail");
			$finish;
		end
	end

	function automatic longint shift_tz(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-v) >>> s);
	endfunction

	function automatic longint arctan_step(int i);
		longint tab[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
		return tab[i];
	endfunction

	function automatic longint predict_model(logic [15:0] v, logic [15:0] t, logic [1:0] e);
		longint u, n, x, y, z, nx, mag;
		u = longint'(v) * longint'(t);
		z = 0;
		case (e)
			EDGE_RIGHT: n = 2097152 - u;
			EDGE_LEFT: n = -(u + 2097152);
			EDGE_TOP: n = u - 2097152;
			default: n = u + 2097152;
		endcase
		if (n > 2095055) n = 2095055;
		if (n < -2095055) n = -2095055;
		if (n == 0)
			return (e == EDGE_RIGHT) ? -11520 : 11520;
		x = longint'(2097152) * 512;
		y = (n < 0 ? -n : n) * 512;
		for (int i = 0; i < 20; i++) begin
			if (y >= 0) begin
				nx = x + shift_tz(y, i);
				y = y - shift_tz(x, i);
				z += arctan_step(i);
			end else begin
				nx = x - shift_tz(y, i);
				y = y + shift_tz(x, i);
				z -= arctan_step(i);
			end
			x = nx;
		end
		mag = 5898240 - z;
		if (mag < 0) mag = 0;
		mag = (mag + 256) / 512;
		return n < 0 ? -mag : mag;
	endfunction

	function automatic yaw_result_t fuse_yaw(logic [15:0] v, logic [15:0] t, logic [1:0] e,
			logic signed [15:0] cam);
		longint model, p1, d, g, fused;
		yaw_result_t r;
		model = predict_model(v, t, e);
		p1 = longint'(cov) + longint'(q_noise);
		if (p1 > 262143) p1 = 262143;
		d = p1 + longint'(r_noise);
		g = 0;
		if (d != 0) begin
			g = (p1 * 65536 + d / 2) / d;
			if (g > 65535) g = 65535;
		end
		fused = model + ((g * (longint'(cam) - model) + 32768) >>> 16);
		cov = 18'(((65536 - g) * p1 + 32768) >> 16);
		r.fused = 16'(fused);
		r.model = 15'(model);
		r.gain = 16'(g);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		yaw_result_t exp_r;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %0d %0d %0d", $time, fused_yaw, geo_yaw,
					filter_gain);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (fused_yaw !== exp_r.fused) begin
					$display("%0t: fused_yaw exp %0d got %0d", $time, exp_r.fused, fused_yaw);
					errors++;
				end
				if (geo_yaw !== exp_r.model) begin
					$display("%0t: geo_yaw exp %0d got %0d", $time, exp_r.model, geo_yaw);
					errors++;
				end
				if (filter_gain !== exp_r.gain) begin
					$display("%0t: filter_gain exp %0d got %0d", $time, exp_r.gain,
						filter_gain);
					errors++;
				end
			end
		end
	end

	// output stall pattern
	always @(posedge clk) begin
		int k;
		k = cycles % 97;
		if (hold_off)
			out_ready <= 1'b0;
		else if (no_stall)
			out_ready <= 1'b1;
		else if (stall_mode == 0)
			out_ready <= (k < 60) || (k % 3 == 0);
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk)
		if ((cycles % 1500) == 0)
			stall_mode <= $urandom_range(0, 1);

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (Drain) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PROCESS_NOISE: q_noise = val;
			REG_MEAS_NOISE: r_noise = val;
			REG_INIT_COV: begin
				p_init = val;
				cov = {2'b00, val};
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// valid stays high between items of a burst; it drops only for a gap
	task automatic send_item(logic [15:0] v, logic [15:0] t, logic [1:0] e,
			logic signed [15:0] cam, bit gaps);
		if (gaps) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		speed <= v;
		edge_time <= t;
		edge_index <= e;
		camera_yaw <= cam;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(fuse_yaw(v, t, e, cam));
	endtask

	function automatic logic signed [15:0] rand_cam();
		return 16'(int'($urandom_range(0, 46080)) - 23040);
	endfunction

	task automatic test_directed();
		no_stall = 1'b1;
		send_item(16'd0, 16'd0, 2'd0, 16'sd0, 0);
		send_item(16'd0, 16'd0, 2'd1, -16'sd23040, 0);
		send_item(16'd0, 16'd0, 2'd2, 16'sd23040, 0);
		send_item(16'd0, 16'd0, 2'd3, 16'sd23040, 0);
		// zero position on right and top edges
		send_item(16'd1024, 16'd2048, 2'd0, 16'sd100, 0);
		send_item(16'd2048, 16'd1024, 2'd2, -16'sd100, 0);
		send_item(16'hFFFF, 16'hFFFF, 2'd0, 16'sd23040, 0);
		send_item(16'hFFFF, 16'hFFFF, 2'd1, -16'sd23040, 0);
		send_item(16'hFFFF, 16'hFFFF, 2'd2, 16'sd5, 0);
		send_item(16'hFFFF, 16'hFFFF, 2'd3, -16'sd5, 0);
		send_item(16'd1, 16'd1, 2'd0, 16'sd0, 0);
		send_item(16'd1, 16'd2097, 2'd2, 16'sd1, 0);
		send_item(16'h5555, 16'h00AA, 2'd1, 16'sh2AAA, 0);
		send_item(16'hAAAA, 16'h0055, 2'd3, -16'sh2AAA, 0);
		wait_idle();
		// zero denominator
		write_reg(REG_PROCESS_NOISE, 16'd0);
		write_reg(REG_MEAS_NOISE, 16'd0);
		write_reg(REG_INIT_COV, 16'd0);
		send_item(16'd300, 16'd500, 2'd0, 16'sd9000, 0);
		wait_idle();
		// gain of one
		write_reg(REG_PROCESS_NOISE, 16'd1);
		send_item(16'd300, 16'd500, 2'd1, -16'sd9000, 0);
		send_item(16'd700, 16'd100, 2'd2, 16'sd23040, 0);
		wait_idle();
		// maximum noise and covariance settings
		write_reg(REG_PROCESS_NOISE, 16'hFFFF);
		write_reg(REG_MEAS_NOISE, 16'hFFFF);
		write_reg(REG_INIT_COV, 16'hFFFF);
		repeat (5) send_item(16'($urandom), 16'($urandom), 2'($urandom), rand_cam(), 0);
		wait_idle();
		// out-of-range register index is ignored
		write_reg(2'd3, 16'h1234);
		send_item(16'd10, 16'd10, 2'd3, 16'sd0, 0);
		wait_idle();
		no_stall = 1'b0;
	endtask

	task automatic test_random(int count);
		logic [15:0] v, t;
		for (int i = 0; i < count; i++) begin
			// favor positions away from the clamp so the arctangent moves
			case ($urandom_range(0, 3))
				0: begin v = 16'($urandom); t = 16'($urandom); end
				1: begin v = 16'($urandom_range(0, 4095)); t = 16'($urandom_range(0, 1023)); end
				default: begin
					v = 16'($urandom_range(0, 2047));
					t = 16'($urandom_range(0, 2047));
				end
			endcase
			send_item(v, t, 2'($urandom), rand_cam(), 1);
		end
	endtask

	task automatic test_config_sweep();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_PROCESS_NOISE, ph == 0 ? 16'd0 : 16'($urandom_range(0, ph * 12000)));
			write_reg(REG_MEAS_NOISE, ph == 1 ? 16'hFFFF : 16'($urandom));
			write_reg(REG_INIT_COV, ph == 2 ? 16'd0 : 16'($urandom));
			test_random(250);
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random(20);
		join
		wait_idle();
	endtask

	initial begin
		q_noise = 16'd26;
		r_noise = 16'd2560;
		p_init = 16'd25600;
		cov = 18'd25600;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		wait_idle();
		test_config_sweep();
		test_backpressure();
		write_reg(REG_PROCESS_NOISE, 16'd26);
		write_reg(REG_MEAS_NOISE, 16'd2560);
		write_reg(REG_INIT_COV, 16'd25600);
		test_random(25);
		wait_idle();
		if (errors == 0)
			$display("scalar_kalman_yaw_fusion_core regression: pass");
		else
			$display("scalar_kalman_yaw_fusion_core regression: fail");
		$finish;
	end

endmodule
